[sv/drc_pkg.sv]
// ============================================================================
// drc_pkg
// Shared types, constants and helpers for the DDA column raycaster.
// ============================================================================
package drc_pkg;

    // Map geometry
    localparam int MAP_SIDE   = 64;
    localparam int MAP_ORIGIN = 32;
    localparam int CELLS      = MAP_SIDE * MAP_SIDE;
    localparam int MEM_DEPTH  = (CELLS < 4096) ? CELLS : 4096;
    localparam int AW         = $clog2(MEM_DEPTH);
    localparam int MSW        = $clog2(MAP_SIDE);
    localparam int CELL_W     = 2 * MSW;
    localparam int COORD_W    = 12;
    localparam int STEP_MAX   = 2 * MAP_SIDE + 2;
    localparam int STEP_W     = $clog2(STEP_MAX + 1);

    // Fixed point widths
    localparam int FRAC     = 16;
    localparam int ONE_Q    = 65536;
    localparam int POS_W    = 26;
    localparam int CFG_W    = 23;
    localparam int VEC_W    = 18;
    localparam int DIM_W    = 12;
    localparam int COL_W    = 11;
    localparam int CAM_W    = 30;
    localparam int PROD_W   = VEC_W + CAM_W;
    localparam int RAY_W    = 32;
    localparam int DELTA_W  = 33;
    localparam int DIST_W   = 17;
    localparam int SIDE_W   = DELTA_W + 2 + STEP_W;
    localparam int NUM_W    = 33;
    localparam int LH_W     = 28;
    localparam int CNT_W    = $clog2(NUM_W);

    // Register indexes
    localparam logic [2:0] CFG_POS_X   = 3'd0;
    localparam logic [2:0] CFG_POS_Y   = 3'd1;
    localparam logic [2:0] CFG_DIR_X   = 3'd2;
    localparam logic [2:0] CFG_DIR_Y   = 3'd3;
    localparam logic [2:0] CFG_PLANE_X = 3'd4;
    localparam logic [2:0] CFG_PLANE_Y = 3'd5;
    localparam logic [2:0] CFG_WIDTH   = 3'd6;
    localparam logic [2:0] CFG_HEIGHT  = 3'd7;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [1:0] TYPE_BLUE = 2'd2;
    localparam logic [7:0] ALPHA_VAL = 8'd100;
    localparam logic [7:0] FULL_VAL  = 8'd255;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CAM_DIV, ST_CAM_WAIT, ST_RAY,
        ST_DX_DIV, ST_DX_WAIT, ST_DY_DIV, ST_DY_WAIT, ST_SIDE,
        ST_STEP, ST_CHECK, ST_PERP, ST_LH_WAIT, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_CAM, DIV_DX, DIV_DY, DIV_LH
    } div_sel_t;

    typedef struct packed {
        logic     clear;
        logic     mem_write;
        logic     load;
        logic     div_start;
        logic     div_capture;
        div_sel_t div_sel;
        logic     ray_calc;
        logic     side_calc;
        logic     step;
        logic     check;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic oob;
        logic cell_hit;
        logic steps_done;
        logic lh_needed;
    } dp_status_t;

    typedef struct packed {
        logic [7:0]       alpha;
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [1:0]       wall_type;
        logic             wall_side;
        logic [COL_W-1:0] draw_end;
        logic [COL_W-1:0] draw_start;
        logic [COL_W-1:0] out_column;
        logic             no_hit;
    } result_t;

    // Screen size limited to 1..2048
    function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(2048))
            r = DIM_W'(2048);
        else
            r = v;
        return r;
    endfunction

endpackage

[sv/drc_div.sv]
// ============================================================================
// drc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module drc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [drc_pkg::NUM_W-1:0]   num,
    input  logic [drc_pkg::SIDE_W-1:0]  den,
    output logic                        done,
    output logic [drc_pkg::NUM_W-1:0]   quo
);
    import drc_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SIDE_W-1:0] rem_reg, rem_next;
    logic [SIDE_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [SIDE_W:0]   trial;
    logic              ge;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            rem_next  = '0;
            den_next  = den;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? SIDE_W'(trial - {1'b0, den_reg}) : trial[SIDE_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[sv/drc_ctrl.sv]
// ============================================================================
// drc_ctrl
// Sequencer for map writes, ray setup, grid walk and stripe sizing.
// ============================================================================
module drc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_op,
    input  logic                   out_free,
    input  drc_pkg::dp_status_t    status,
    output logic                   in_ready,
    output drc_pkg::ctrl_cmd_t     cmd
);
    import drc_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (status.clear_done) state_next = ST_IDLE;
            ST_IDLE:     if (in_valid && in_op == OP_CAST) state_next = ST_CAM_DIV;
            ST_CAM_DIV:  state_next = ST_CAM_WAIT;
            ST_CAM_WAIT: if (status.div_done) state_next = ST_RAY;
            ST_RAY:      state_next = ST_DX_DIV;
            ST_DX_DIV:   state_next = ST_DX_WAIT;
            ST_DX_WAIT:  if (status.div_done) state_next = ST_DY_DIV;
            ST_DY_DIV:   state_next = ST_DY_WAIT;
            ST_DY_WAIT:  if (status.div_done) state_next = ST_SIDE;
            ST_SIDE:     state_next = ST_STEP;
            ST_STEP:     state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (status.oob)
                    state_next = ST_DONE;
                else if (status.cell_hit)
                    state_next = ST_PERP;
                else if (status.steps_done)
                    state_next = ST_DONE;
                else
                    state_next = ST_STEP;
            end
            ST_PERP:     state_next = status.lh_needed ? ST_LH_WAIT : ST_DONE;
            ST_LH_WAIT:  if (status.div_done) state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.div_sel = DIV_CAM;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:    cmd.clear = 1'b1;
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.mem_write = in_valid && in_op == OP_WRITE;
                cmd.load      = in_valid && in_op == OP_CAST;
            end
            ST_CAM_DIV:  cmd.div_start = 1'b1;
            ST_CAM_WAIT: cmd.div_capture = status.div_done;
            ST_RAY:      cmd.ray_calc = 1'b1;
            ST_DX_DIV:
            begin
                cmd.div_sel   = DIV_DX;
                cmd.div_start = 1'b1;
            end
            ST_DX_WAIT:
            begin
                cmd.div_sel     = DIV_DX;
                cmd.div_capture = status.div_done;
            end
            ST_DY_DIV:
            begin
                cmd.div_sel   = DIV_DY;
                cmd.div_start = 1'b1;
            end
            ST_DY_WAIT:
            begin
                cmd.div_sel     = DIV_DY;
                cmd.div_capture = status.div_done;
            end
            ST_SIDE:     cmd.side_calc = 1'b1;
            ST_STEP:     cmd.step = 1'b1;
            ST_CHECK:    cmd.check = 1'b1;
            ST_PERP:
            begin
                cmd.div_sel   = DIV_LH;
                cmd.div_start = status.lh_needed;
            end
            ST_LH_WAIT:
            begin
                cmd.div_sel     = DIV_LH;
                cmd.div_capture = status.div_done;
            end
            ST_DONE:     cmd.out_load = out_free;
            default:     cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

[sv/drc_datapath.sv]
// ============================================================================
// drc_datapath
// Registers, map memory, shared divider and DDA walk arithmetic.
// ============================================================================
module drc_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [drc_pkg::CFG_W-1:0]    cfg_data,
    input  logic [11:0]                  in_index,
    input  logic [1:0]                   in_value,
    input  logic [drc_pkg::COL_W-1:0]    in_column,
    input  drc_pkg::ctrl_cmd_t           cmd,
    output drc_pkg::dp_status_t          status,
    output drc_pkg::result_t             res
);
    import drc_pkg::*;

    // Configuration
    logic signed [CFG_W-1:0] pos_x_reg, pos_y_reg;
    logic signed [VEC_W-1:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [DIM_W-1:0]        width_reg, height_reg;
    logic [DIM_W-1:0]        w_dim, h_dim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= -CFG_W'(1048576);
            pos_y_reg   <= CFG_W'(1048576);
            dir_x_reg   <= VEC_W'(65536);
            dir_y_reg   <= '0;
            plane_x_reg <= '0;
            plane_y_reg <= VEC_W'(50463);
            width_reg   <= DIM_W'(1280);
            height_reg  <= DIM_W'(720);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POS_X:   pos_x_reg   <= cfg_data;
                CFG_POS_Y:   pos_y_reg   <= cfg_data;
                CFG_DIR_X:   dir_x_reg   <= cfg_data[VEC_W-1:0];
                CFG_DIR_Y:   dir_y_reg   <= cfg_data[VEC_W-1:0];
                CFG_PLANE_X: plane_x_reg <= cfg_data[VEC_W-1:0];
                CFG_PLANE_Y: plane_y_reg <= cfg_data[VEC_W-1:0];
                CFG_WIDTH:   width_reg   <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:  height_reg  <= cfg_data[DIM_W-1:0];
                default:     ;
            endcase
        end
    end

    assign w_dim = dim_clamp(width_reg);
    assign h_dim = dim_clamp(height_reg);

    // Item and walk state
    logic [COL_W-1:0]          col_reg;
    logic signed [CAM_W-1:0]   cam_reg;
    logic signed [RAY_W-1:0]   rx_reg, ry_reg;
    logic [DELTA_W-1:0]        dx_reg, dy_reg;
    logic [SIDE_W-1:0]         side_x_reg, side_y_reg;
    logic                      sx_inf_reg, sy_inf_reg;
    logic signed [COORD_W-1:0] mx_reg, my_reg;
    logic [FRAC-1:0]           fx_reg, fy_reg;
    logic [STEP_W-1:0]         step_cnt_reg;
    logic                      side_reg, oob_reg, hit_reg;
    logic [1:0]                type_reg;
    logic [LH_W-1:0]           lh_reg;
    logic [AW-1:0]             clr_cnt_reg;
    logic [1:0]                mem_q_reg;

    logic [1:0] mem [MEM_DEPTH];

    // Start position in map space
    logic signed [POS_W-1:0] px, py;
    assign px = $signed({10'(MAP_ORIGIN), 16'd0}) + POS_W'(pos_x_reg);
    assign py = $signed({10'(MAP_ORIGIN), 16'd0}) - POS_W'(pos_y_reg);

    // Ray products
    logic signed [PROD_W-1:0] prod_x, prod_y;
    assign prod_x = plane_x_reg * cam_reg;
    assign prod_y = plane_y_reg * cam_reg;

    // Side distance setup
    logic [DIST_W-1:0]        dist_x, dist_y;
    logic [DIST_W+DELTA_W-1:0] sdx, sdy;
    assign dist_x = rx_reg[RAY_W-1] ? {1'b0, fx_reg} : DIST_W'(ONE_Q) - {1'b0, fx_reg};
    assign dist_y = ry_reg[RAY_W-1] ? {1'b0, fy_reg} : DIST_W'(ONE_Q) - {1'b0, fy_reg};
    assign sdx    = dist_x * dx_reg;
    assign sdy    = dist_y * dy_reg;

    // Absolute ray components, a zero one divides by one and is flagged infinite
    logic [RAY_W-1:0] rx_abs, ry_abs;
    assign rx_abs = (rx_reg == '0) ? RAY_W'(1) :
                    (rx_reg[RAY_W-1] ? RAY_W'(-rx_reg) : RAY_W'(rx_reg));
    assign ry_abs = (ry_reg == '0) ? RAY_W'(1) :
                    (ry_reg[RAY_W-1] ? RAY_W'(-ry_reg) : RAY_W'(ry_reg));

    // Perpendicular distance
    logic              perp_inf, perp_zero;
    logic [SIDE_W-1:0] perp;
    assign perp_inf  = side_reg ? sy_inf_reg : sx_inf_reg;
    assign perp      = side_reg ? side_y_reg - SIDE_W'(dy_reg) : side_x_reg - SIDE_W'(dx_reg);
    assign perp_zero = !perp_inf && perp == '0;

    // Shared divider
    logic [NUM_W-1:0]  div_num, div_quo;
    logic [SIDE_W-1:0] div_den;
    logic              div_done;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_CAM:
            begin
                div_num = NUM_W'({col_reg, 17'd0});
                div_den = SIDE_W'(w_dim);
            end
            DIV_DX:
            begin
                div_num = {1'b1, 32'd0};
                div_den = SIDE_W'(rx_abs);
            end
            DIV_DY:
            begin
                div_num = {1'b1, 32'd0};
                div_den = SIDE_W'(ry_abs);
            end
            DIV_LH:
            begin
                div_num = NUM_W'({h_dim, 16'd0});
                div_den = perp;
            end
            default:
            begin
                div_num = '0;
                div_den = SIDE_W'(1);
            end
        endcase
    end

    drc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // DDA step
    logic                      x_first;
    logic signed [COORD_W-1:0] mx_next, my_next;
    logic                      in_map;
    logic [CELL_W-1:0]         rd_addr;
    logic                      rd_ok;

    assign x_first = !sx_inf_reg && (sy_inf_reg || side_x_reg < side_y_reg);
    assign mx_next = !x_first ? mx_reg :
                     (rx_reg[RAY_W-1] ? mx_reg - 1'b1 : mx_reg + 1'b1);
    assign my_next = x_first ? my_reg :
                     (ry_reg[RAY_W-1] ? my_reg - 1'b1 : my_reg + 1'b1);
    assign in_map  = !mx_next[COORD_W-1] && !my_next[COORD_W-1]
                     && $unsigned(mx_next) < COORD_W'(MAP_SIDE)
                     && $unsigned(my_next) < COORD_W'(MAP_SIDE);
    assign rd_addr = CELL_W'(my_next[MSW-1:0]) * CELL_W'(MAP_SIDE)
                     + CELL_W'(mx_next[MSW-1:0]);
    assign rd_ok   = in_map && ({1'b0, rd_addr} < (CELL_W+1)'(MEM_DEPTH));

    // Map memory, cleared by a sweep after reset
    logic wr_ok;
    assign wr_ok = {1'b0, in_index} < 13'(MEM_DEPTH);

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
            mem[clr_cnt_reg] <= '0;
        else if (cmd.mem_write && wr_ok)
            mem[in_index[AW-1:0]] <= in_value;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
            mem_q_reg <= rd_ok ? mem[rd_addr[AW-1:0]] : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            step_cnt_reg <= '0;
            hit_reg      <= 1'b0;
            oob_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.load)
            begin
                step_cnt_reg <= '0;
                hit_reg      <= 1'b0;
            end
            if (cmd.step)
            begin
                step_cnt_reg <= step_cnt_reg + 1'b1;
                oob_reg      <= !in_map;
            end
            if (cmd.check)
                hit_reg <= !oob_reg && mem_q_reg != 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            col_reg <= in_column;
            mx_reg  <= COORD_W'($signed(px[POS_W-1:FRAC]));
            my_reg  <= COORD_W'($signed(py[POS_W-1:FRAC]));
            fx_reg  <= px[FRAC-1:0];
            fy_reg  <= py[FRAC-1:0];
        end
        if (cmd.div_capture)
        begin
            case (cmd.div_sel)
                DIV_CAM: cam_reg <= div_quo[CAM_W-1:0] - CAM_W'(ONE_Q);
                DIV_DX:  dx_reg  <= div_quo;
                DIV_DY:  dy_reg  <= div_quo;
                DIV_LH:  lh_reg  <= div_quo[LH_W-1:0];
                default: ;
            endcase
        end
        if (cmd.ray_calc)
        begin
            rx_reg <= RAY_W'(dir_x_reg) - $signed(prod_x[PROD_W-1:FRAC]);
            ry_reg <= $signed(prod_y[PROD_W-1:FRAC]) - RAY_W'(dir_y_reg);
        end
        if (cmd.side_calc)
        begin
            side_x_reg <= SIDE_W'(sdx[DIST_W+DELTA_W-1:FRAC]);
            side_y_reg <= SIDE_W'(sdy[DIST_W+DELTA_W-1:FRAC]);
            sx_inf_reg <= rx_reg == '0;
            sy_inf_reg <= ry_reg == '0;
        end
        if (cmd.step)
        begin
            mx_reg   <= mx_next;
            my_reg   <= my_next;
            side_reg <= !x_first;
            if (x_first)
                side_x_reg <= side_x_reg + SIDE_W'(dx_reg);
            else if (!sy_inf_reg)
                side_y_reg <= side_y_reg + SIDE_W'(dy_reg);
        end
        if (cmd.check)
            type_reg <= mem_q_reg;
    end

    assign status.clear_done = clr_cnt_reg == AW'(MEM_DEPTH - 1);
    assign status.div_done   = div_done;
    assign status.oob        = oob_reg;
    assign status.cell_hit   = mem_q_reg != 2'd0;
    assign status.steps_done = step_cnt_reg == STEP_W'(STEP_MAX);
    assign status.lh_needed  = !perp_inf && !perp_zero;

    // Stripe rows and colour
    logic [LH_W-1:0]  lh_eff, half_lh, end_sum;
    logic [DIM_W-1:0] half_h;
    logic [COL_W-1:0] row_start, row_end;
    logic [7:0]       red_c, blue_c;

    assign lh_eff  = perp_inf ? '0 : lh_reg;
    assign half_lh = lh_eff >> 1;
    assign half_h  = h_dim >> 1;
    assign end_sum = half_lh + LH_W'(half_h);

    always_comb
    begin
        if (perp_zero || half_lh > LH_W'(half_h))
            row_start = '0;
        else
            row_start = COL_W'(half_h - DIM_W'(half_lh));
        if (perp_zero || end_sum >= LH_W'(h_dim))
            row_end = COL_W'(h_dim - 1'b1);
        else
            row_end = COL_W'(end_sum);
    end

    assign red_c  = (type_reg == TYPE_BLUE) ? 8'd0 : FULL_VAL;
    assign blue_c = (type_reg == TYPE_BLUE) ? FULL_VAL : 8'd0;

    always_comb
    begin
        res            = '0;
        res.out_column = col_reg;
        res.no_hit     = !hit_reg;
        if (hit_reg)
        begin
            res.draw_start = row_start;
            res.draw_end   = row_end;
            res.wall_side  = side_reg;
            res.wall_type  = type_reg;
            res.red        = side_reg ? red_c >> 1 : red_c;
            res.green      = 8'd0;
            res.blue       = side_reg ? blue_c >> 1 : blue_c;
            res.alpha      = ALPHA_VAL;
        end
    end

endmodule

[sv/dda_raycast_column.sv]
// ============================================================================
// dda_raycast_column
// Grid raycaster: map cell writes and one wall stripe per cast column.
// ============================================================================
//  channel   direction  tdata                              tuser
//  s_axis    in         cell_index, cell_value, column     operation
//  m_axis    out        column, rows, side, type, RGBA     no_hit
//  cfg       in         eight registers by index           -
//
//  After reset all MEM_DEPTH (4096) map cells are swept to zero with no item
//  taken. A cast runs divider passes for camera and step sizes (start, 33
//  quotient bits, capture), walks the grid cell by cell (registered map
//  read), and runs one more pass if the stripe height is divided out.
//  One result waits in the output register while the next item is accepted;
//  a full output stalls the cast.
// ============================================================================
module dda_raycast_column (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,  // cell_index, cell_value, column
    input  logic                       s_axis_tuser,  // operation
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [71:0]                m_axis_tdata,  // out_column, draw_start, draw_end,
                                                      // wall_side, wall_type, red, green,
                                                      // blue, alpha
    output logic                       m_axis_tuser,  // no_hit
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [drc_pkg::CFG_W-1:0]  cfg_data
);
    import drc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    result_t    res;
    result_t    out_reg;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_axis_tready;

    drc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .out_free (out_free),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    drc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_index  (s_axis_tdata[11:0]),
        .in_value  (s_axis_tdata[13:12]),
        .in_column (s_axis_tdata[24:14]),
        .cmd       (cmd),
        .status    (status),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.no_hit;
    assign m_axis_tdata  = {4'd0, out_reg.alpha, out_reg.blue, out_reg.green, out_reg.red,
                            out_reg.wall_type, out_reg.wall_side, out_reg.draw_end,
                            out_reg.draw_start, out_reg.out_column};

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded over an untaken result");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_CAST) |=> !s_axis_tready)
        else $error("new item taken during a cast");

    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[67:11] == '0)
        else $error("miss result carries stripe data");
`endif

endmodule
